/* hw/rtl/aob_pkg.sv */
// ----------------------------------------------------------------------------
// aob_pkg
// Shared types, codes and table builders of the additive oscillator bank.
// ----------------------------------------------------------------------------
`default_nettype none

package aob_pkg;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_SAMPLE  = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [2:0] REG_FRAME_LEN   = 3'd0;
  localparam logic [2:0] REG_FRAME_RECIP = 3'd1;
  localparam logic [2:0] REG_BASE_STEP   = 3'd2;
  localparam logic [2:0] REG_OUT_GAIN    = 3'd3;
  localparam logic [2:0] REG_ACTIVE      = 3'd4;

  localparam int PIDX_W = 4;

  localparam logic [63:0] LN2_Q30     = 64'd744261118;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef struct packed {
    logic [15:0] off;
    logic [15:0] gain;
  } row_ent_t;

  typedef struct packed {
    logic              wr_ctl;
    logic              restart;
    logic              calc_w;
    logic              issue;
    logic [PIDX_W-1:0] p_idx;
    logic              finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic pipe_empty;
  } dp_sts_t;

  // shift-subtract quotient, used only while the tables are built
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // 2^(k/2^bits) in Q1.16
  function automatic logic [16:0] exp_entry(int unsigned k, int unsigned bits);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned n;
    x    = 64'(k) << (30 - bits);
    y    = (x * LN2_Q30) >> 30;
    sum  = ONE_Q30;
    term = ONE_Q30;
    for (n = 1; n <= 16; n++) begin
      term = udiv64((term * y) >> 30, 64'(n));
      sum  = sum + term;
    end
    return 17'((sum + 64'd8192) >> 14);
  endfunction

  // sin of a quarter-wave step, scale 32767
  function automatic logic [14:0] qsine_entry(int unsigned a, int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    int unsigned n;
    x    = (64'(a) * HALF_PI_Q30) >> (bits - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (n = 1; n <= 10; n++) begin
      term = udiv64((term * x2) >> 30, 64'(2 * n) * 64'(2 * n + 1));
      if ((n & 1) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
    return 15'((64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/aob_ctrl.sv */
// ----------------------------------------------------------------------------
// aob_ctrl
// Command sequencer: decodes input beats, issues partials, drives output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module aob_ctrl import aob_pkg::*; #(
  parameter int MAX_PARTIALS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_command,
  input  wire logic       out_stall,
  output logic            out_valid,
  input  wire logic [3:0] active,
  input  wire dp_sts_t    sts,
  output ctl_cmd_t        cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;

  logic [2:0]        state_r, state_nxt;
  logic [PIDX_W-1:0] p_r, p_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [4:0]        n_eff;

  assign n_eff     = (32'(active) > MAX_PARTIALS) ? 5'(MAX_PARTIALS) : {1'b0, active};
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.p_idx     = p_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_command)
            CMD_WRITE:   cmd.wr_ctl = 1'b1;
            CMD_RESTART: cmd.restart = 1'b1;
            CMD_SAMPLE: begin
              cmd.calc_w = 1'b1;
              p_nxt      = '0;
              state_nxt  = (n_eff == 5'd0) ? S_DRAIN : S_ISSUE;
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if ({1'b0, p_r} == n_eff - 5'd1) begin
          state_nxt = S_DRAIN;
        end else begin
          p_nxt = p_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_empty) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      p_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_r         <= p_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/aob_datapath.sv */
// ----------------------------------------------------------------------------
// aob_datapath
// Control rows, phase accumulators and the per-partial oscillator pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module aob_datapath import aob_pkg::*; #(
  parameter int MAX_PARTIALS    = 8,
  parameter int SINE_TABLE_BITS = 10,
  parameter int EXP_TABLE_BITS  = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ctl_cmd_t           cmd,
  input  wire logic [2:0]         in_partial,
  input  wire logic               in_kind,
  input  wire logic signed [15:0] in_value,
  input  wire logic [10:0]        frame_length,
  input  wire logic [15:0]        frame_recip,
  input  wire logic [22:0]        base_step,
  input  wire logic [14:0]        output_gain,
  output dp_sts_t                 sts,
  output logic signed [19:0]      out_sample
);

  localparam int PW       = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
  localparam int EXP_SIZE = 1 << EXP_TABLE_BITS;
  localparam int QSIZE    = 1 << (SINE_TABLE_BITS - 2);

  typedef logic [16:0] exp_arr_t [EXP_SIZE];
  typedef logic [14:0] qs_arr_t [QSIZE + 1];

  function automatic exp_arr_t build_exp();
    exp_arr_t t;
    for (int k = 0; k < EXP_SIZE; k++) t[k] = exp_entry(k, EXP_TABLE_BITS);
    return t;
  endfunction

  function automatic qs_arr_t build_qsine();
    qs_arr_t t;
    for (int a = 0; a <= QSIZE; a++) t[a] = qsine_entry(a, SINE_TABLE_BITS);
    return t;
  endfunction

  localparam exp_arr_t EXP_TAB = build_exp();
  localparam qs_arr_t  QS_TAB  = build_qsine();

  row_ent_t    cur_r [MAX_PARTIALS];
  row_ent_t    nxt_r [MAX_PARTIALS];
  logic [23:0] phase_r [MAX_PARTIALS];
  logic [9:0]  pos_r;
  logic [16:0] w_r;
  logic signed [51:0] acc_r;
  logic signed [19:0] sample_r;

  // stage 1
  logic          v1_r;
  row_ent_t      c1_r, n1_r;
  logic [23:0]   ph1_r;
  logic [27:0]   bsp1_r;
  logic [PW-1:0] p1_r;
  // stage 2
  logic          v2_r;
  logic [15:0]   uoff2_r, ugain2_r;
  logic [23:0]   ph2_r;
  logic [27:0]   bsp2_r;
  logic [PW-1:0] p2_r;
  // stage 3
  logic          v3_r;
  logic [23:0]   step3_r;
  logic signed [31:0] gp3_r;
  logic [23:0]   ph3_r;
  logic [PW-1:0] p3_r;
  // stage 4
  logic          v4_r;
  logic signed [15:0] s4_r;
  logic signed [31:0] gp4_r;
  // stage 5
  logic          v5_r;
  logic signed [47:0] term5_r;

  logic [PW-1:0] ip;
  logic [25:0]   wprod;
  logic [16:0]   w_sat;
  logic [16:0]   wc;
  logic [32:0]   io_sum, ig_sum;
  logic [44:0]   prod;
  logic [44:0]   prod_sh;
  logic [23:0]   ph_new;
  logic [SINE_TABLE_BITS-1:0] sidx;
  logic [1:0]    quad;
  logic [SINE_TABLE_BITS-3:0] srem;
  logic [SINE_TABLE_BITS-2:0] qa;
  logic [14:0]   qv;
  logic signed [15:0] gsig;
  logic signed [51:0] rnd;
  logic signed [21:0] shv;
  logic signed [19:0] sat;
  logic [10:0]   len_eff;
  logic [10:0]   pos_inc;

  assign ip    = cmd.p_idx[PW-1:0];
  assign wprod = pos_r * frame_recip;
  assign w_sat = (wprod > 26'd65536) ? 17'd65536 : wprod[16:0];
  assign wc    = 17'd65536 - w_r;

  assign io_sum = {17'd0, c1_r.off ^ 16'h8000} * {16'd0, wc}
                + {17'd0, n1_r.off ^ 16'h8000} * {16'd0, w_r} + 33'd32768;
  assign ig_sum = {17'd0, c1_r.gain ^ 16'h8000} * {16'd0, wc}
                + {17'd0, n1_r.gain ^ 16'h8000} * {16'd0, w_r} + 33'd32768;

  assign prod    = {17'd0, bsp2_r} * {28'd0, EXP_TAB[uoff2_r[14 -: EXP_TABLE_BITS]]};
  assign prod_sh = uoff2_r[15] ? (prod >> 16) : (prod >> 17);
  assign gsig    = $signed({~ugain2_r[15], ugain2_r[14:0]});

  assign ph_new = ph3_r + step3_r;
  assign sidx   = ph_new[23 -: SINE_TABLE_BITS];
  assign quad   = sidx[SINE_TABLE_BITS-1 -: 2];
  assign srem   = sidx[SINE_TABLE_BITS-3:0];
  assign qa     = quad[0] ? (SINE_TABLE_BITS-1)'(QSIZE) - {1'b0, srem} : {1'b0, srem};
  assign qv     = QS_TAB[qa];

  assign rnd = acc_r + 52'sd536870912;
  assign shv = 22'(rnd >>> 30);
  assign sat = (shv > 22'sd524287) ? 20'sd524287 :
               (shv < -22'sd524288) ? -20'sd524288 : shv[19:0];

  assign len_eff = (frame_length == 11'd0) ? 11'd1 :
                   (frame_length > 11'd1024) ? 11'd1024 : frame_length;
  assign pos_inc = {1'b0, pos_r} + 11'd1;

  assign sts.pipe_empty = !(v1_r || v2_r || v3_r || v4_r || v5_r);
  assign out_sample     = sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PARTIALS; i++) begin
        cur_r[i]   <= '0;
        nxt_r[i]   <= '0;
        phase_r[i] <= '0;
      end
      pos_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      if (cmd.wr_ctl && (32'(in_partial) < MAX_PARTIALS)) begin
        if (in_kind) nxt_r[in_partial[PW-1:0]].gain <= in_value;
        else nxt_r[in_partial[PW-1:0]].off <= in_value;
      end
      if (v3_r) phase_r[p3_r] <= ph_new;
      if (cmd.restart) begin
        for (int i = 0; i < MAX_PARTIALS; i++) phase_r[i] <= '0;
        pos_r <= '0;
        cur_r <= nxt_r;
      end
      if (cmd.finish) begin
        if (pos_inc >= len_eff) begin
          pos_r <= '0;
          cur_r <= nxt_r;
        end else begin
          pos_r <= pos_inc[9:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_w) w_r <= w_sat;
    c1_r     <= cur_r[ip];
    n1_r     <= nxt_r[ip];
    ph1_r    <= phase_r[ip];
    bsp1_r   <= {5'd0, base_step} * {23'd0, 5'({1'b0, cmd.p_idx}) + 5'd1};
    p1_r     <= ip;
    uoff2_r  <= io_sum[31:16];
    ugain2_r <= ig_sum[31:16];
    ph2_r    <= ph1_r;
    bsp2_r   <= bsp1_r;
    p2_r     <= p1_r;
    step3_r  <= prod_sh[23:0];
    gp3_r    <= gsig * $signed({17'd0, output_gain});
    ph3_r    <= ph2_r;
    p3_r     <= p2_r;
    s4_r     <= quad[1] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
    gp4_r    <= gp3_r;
    term5_r  <= gp4_r * s4_r;
    if (cmd.calc_w) acc_r <= '0;
    else if (v5_r) acc_r <= acc_r + 52'(term5_r);
    if (cmd.finish) sample_r <= sat;
  end

endmodule

`default_nettype wire

/* hw/rtl/additive_oscillator_bank_top.sv */
// ----------------------------------------------------------------------------
// additive_oscillator_bank_top
// Additive synthesizer, one sine oscillator per harmonic partial.
// ----------------------------------------------------------------------------
// Write and restart beats are taken without stalling the input.
// A sample beat issues n partials, drains the oscillator pipeline, then raises out_valid;
// n = active partials (capped at MAX_PARTIALS); one partial enters the pipeline per cycle.
// Input stalls while a sample runs, and longer while a finished sample waits in the
// output reg.
// Synchronous reset: rows, phases and frame position clear, registers load defaults.
`default_nettype none

module additive_oscillator_bank_top import aob_pkg::*; #(
  parameter int MAX_PARTIALS    = 8,
  parameter int SINE_TABLE_BITS = 10,
  parameter int EXP_TABLE_BITS  = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_command,
  input  wire logic [2:0]         in_partial,
  input  wire logic               in_kind,
  input  wire logic signed [15:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [19:0]      out_sample,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [10:0] frame_len_r;
  logic [15:0] frame_recip_r;
  logic [22:0] base_step_r;
  logic [14:0] out_gain_r;
  logic [3:0]  active_r;
  logic        cfg_wr;
  ctl_cmd_t    cmd;
  dp_sts_t     sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r   <= 11'd240;
      frame_recip_r <= 16'd273;
      base_step_r   <= 23'd139810;
      out_gain_r    <= 15'd5898;
      active_r      <= 4'd6;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_FRAME_LEN:   frame_len_r   <= pwdata[10:0];
        REG_FRAME_RECIP: frame_recip_r <= pwdata[15:0];
        REG_BASE_STEP:   base_step_r   <= pwdata[22:0];
        REG_OUT_GAIN:    out_gain_r    <= pwdata[14:0];
        REG_ACTIVE:      active_r      <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_FRAME_LEN:   prdata = {21'd0, frame_len_r};
      REG_FRAME_RECIP: prdata = {16'd0, frame_recip_r};
      REG_BASE_STEP:   prdata = {9'd0, base_step_r};
      REG_OUT_GAIN:    prdata = {17'd0, out_gain_r};
      REG_ACTIVE:      prdata = {28'd0, active_r};
      default:         prdata = '0;
    endcase
  end

  aob_ctrl #(
    .MAX_PARTIALS(MAX_PARTIALS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_command(in_command),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .active    (active_r),
    .sts       (sts),
    .cmd       (cmd)
  );

  aob_datapath #(
    .MAX_PARTIALS   (MAX_PARTIALS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS),
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_partial  (in_partial),
    .in_kind     (in_kind),
    .in_value    (in_value),
    .frame_length(frame_len_r),
    .frame_recip (frame_recip_r),
    .base_step   (base_step_r),
    .output_gain (out_gain_r),
    .sts         (sts),
    .out_sample  (out_sample)
  );

  a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.pipe_empty)
    else $error("sample finished with partials still in flight");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("out_valid rose without a finished sample");

  a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> in_stall)
    else $error("partial issued while input open");

endmodule

`default_nettype wire
